// File: src/gpef_pkg.sv
// glyph pixel effect filter package: sizes, codes, config and control types
// no dependencies; used by gpef_regs, gpef_ctrl, gpef_dp and the top file
`timescale 1ns / 1ps
`default_nettype none

package gpef_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W      = 8;
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_EFF_W  = 2;

  localparam int RING_DEPTH = 4 * MAX_WIDTH + 5;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int OFF_W      = $clog2(2 * MAX_WIDTH + 3) + 1;
  localparam int AD_W       = RING_AW + 2;
  localparam int POS_W      = CNT_W + 2;

  localparam int GLOW_SIZE  = 5;
  localparam int GLOW_TAPS  = GLOW_SIZE * GLOW_SIZE;
  localparam int RELIEF_TAPS = 2;
  localparam int TAP_CNT_W  = $clog2(GLOW_TAPS);
  localparam int COL_W      = $clog2(GLOW_SIZE);
  localparam int SUM_W      = $clog2(GLOW_TAPS * 255 + 1);

  localparam int GLOW_DIV     = 6375;
  localparam int GLOW_SHIFT   = 34;
  localparam int GLOW_RECIP_W = 22;
  localparam longint unsigned GLOW_RECIP =
    ((64'd1 << GLOW_SHIFT) + 64'(GLOW_DIV) - 64'd1) / 64'(GLOW_DIV);
  localparam int GPROD_W      = PIX_W + SUM_W;
  localparam int GFULL_W      = GPROD_W + GLOW_RECIP_W;

  localparam int RELIEF_BIAS  = 200;
  localparam int RELIEF_DIV   = 255;
  localparam int RELIEF_SHIFT = 23;
  localparam int RELIEF_RECIP = ((1 << RELIEF_SHIFT) + RELIEF_DIV - 1) / RELIEF_DIV;
  localparam int RELIEF_SAT   = 256 * RELIEF_DIV;
  localparam int REL_T_W      = PIX_W + 2;
  localparam int REL_V_W      = REL_T_W + PIX_W + 1;
  localparam int REL_Q_W      = 16;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [CFG_EFF_W-1:0] {
    EFF_GLOW = 2'd0,
    EFF_HREL = 2'd1,
    EFF_DREL = 2'd2
  } effect_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_EFFECT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_READ  = 3'd1,
    ST_FLUSH = 3'd2,
    ST_MUL   = 3'd3,
    ST_DIV   = 3'd4,
    ST_WRITE = 3'd5
  } state_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic [CFG_EFF_W-1:0] effect;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic win_init;
    logic rd_en;
    logic mul_en;
    logic div_en;
    logic wr_en;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic glow;
    logic out_free;
  } dp_sts_t;

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] ptr);
    logic [RING_AW-1:0] nxt;
    if (ptr == RING_AW'(RING_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + RING_AW'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: src/gpef_in_if.sv
// input channel of the glyph pixel effect filter: valid/ready with mode and pixel
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface gpef_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

`default_nettype wire

// File: src/gpef_out_if.sv
// output channel of the glyph pixel effect filter: valid/ready with result pixel
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface gpef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// File: src/gpef_regs.sv
// apb configuration registers: frame width, frame height, effect select
// depends on gpef_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpef_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gpef_pkg::PADDR_W-1:0]   paddr,
  input  logic [gpef_pkg::PDATA_W-1:0]   pwdata,
  output logic [gpef_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output gpef_pkg::cfg_t                 cfg_o,
  output logic                           restart_o
);
  import gpef_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_fire;

  assign idx     = paddr[PADDR_W-1:2];
  assign wr_fire = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d     = cfg_q;
    restart_o = 1'b0;
    if (wr_fire) begin
      case (idx)
        REG_WIDTH: begin
          cfg_d.frame_width = pwdata[CFG_DIM_W-1:0];
          restart_o         = 1'b1;
        end
        REG_HEIGHT: begin
          cfg_d.frame_height = pwdata[CFG_DIM_W-1:0];
          restart_o          = 1'b1;
        end
        REG_EFFECT: begin
          cfg_d.effect = pwdata[CFG_EFF_W-1:0];
          restart_o    = 1'b1;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = PDATA_W'(cfg_q.frame_width);
      REG_HEIGHT: prdata = PDATA_W'(cfg_q.frame_height);
      REG_EFFECT: prdata = PDATA_W'(cfg_q.effect);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= CFG_DIM_W'(MAX_WIDTH);
      cfg_q.frame_height <= CFG_DIM_W'(MAX_HEIGHT);
      cfg_q.effect       <= EFF_GLOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: src/gpef_ctrl.sv
// sequencing fsm: accept, window reads, multiply, divide, write-back and result beat
// depends on gpef_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpef_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gpef_pkg::dp_sts_t sts_i,
  output gpef_pkg::dp_cmd_t cmd_o
);
  import gpef_pkg::*;

  state_e                 state_q, state_d;
  logic [TAP_CNT_W-1:0]   tap_q, tap_d;
  logic                   last_tap;

  assign last_tap = sts_i.glow ? (tap_q == TAP_CNT_W'(GLOW_TAPS - 1))
                               : (tap_q == TAP_CNT_W'(RELIEF_TAPS - 1));

  assign tap_d = (state_q == ST_READ && !last_tap) ? tap_q + TAP_CNT_W'(1) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.emit_req) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (last_tap) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_WRITE;
      ST_WRITE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.accept   = in_valid_i;
        cmd_o.win_init = in_valid_i && sts_i.emit_req;
      end
      ST_READ:  cmd_o.rd_en  = 1'b1;
      ST_MUL:   cmd_o.mul_en = 1'b1;
      ST_DIV:   cmd_o.div_en = 1'b1;
      ST_WRITE: cmd_o.wr_en  = sts_i.out_free;
      default:  cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.rd_en, cmd_o.mul_en, cmd_o.div_en, cmd_o.wr_en}))
    else $error("more than one datapath phase active");

  a_window_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.win_init |=> (state_q == ST_READ) && (tap_q == '0))
    else $error("window read did not start at tap zero");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) && !sts_i.out_free |=> state_q == ST_WRITE)
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

// File: src/gpef_dp.sv
// datapath: ring memory, frame counters, window address walk, glow and relief math,
// output register; depends on gpef_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpef_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gpef_pkg::cfg_t               cfg_i,
  input  logic                         restart_i,
  input  gpef_pkg::dp_cmd_t            cmd_i,
  output gpef_pkg::dp_sts_t            sts_o,
  input  logic                         in_mode_i,
  input  logic [gpef_pkg::PIX_W-1:0]   in_pixel_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [gpef_pkg::PIX_W-1:0]   out_pixel_o,
  output logic                         out_end_o
);
  import gpef_pkg::*;

  // effective frame size
  logic [WID_W-1:0]       eff_w;
  logic [HGT_W-1:0]       eff_h;
  logic [CNT_W-1:0]       total;
  logic [CNT_W:0]         lag_thr;
  logic [CNT_W:0]         fill;
  logic                   pix_ok;
  logic                   pix_take;
  logic                   frame_done;
  logic                   glow;

  // counters and ring pointers
  logic [CNT_W-1:0]       acc_q, acc_d, emit_q, emit_d;
  logic [RING_AW-1:0]     acc_ptr_q, acc_ptr_d, emit_ptr_q, emit_ptr_d;

  // ring memory
  logic [PIX_W-1:0]       ring_mem [RING_DEPTH];
  logic                   mem_we;
  logic [RING_AW-1:0]     mem_waddr;
  logic [PIX_W-1:0]       mem_wdata;
  logic [PIX_W-1:0]       mem_rdata_q;

  // window walk
  logic signed [OFF_W-1:0] off_q, off_d, w_off;
  logic [COL_W-1:0]       col_q, col_d;
  logic signed [AD_W-1:0] addr_raw;
  logic [RING_AW-1:0]     rd_addr;
  logic signed [POS_W-1:0] pos;
  logic                   pos_in;
  logic                   rd_vld_q, rd_in_q, rd_ctr_q, rd_isq_q;
  logic [PIX_W-1:0]       rd_val;
  logic [SUM_W-1:0]       sum_q;
  logic [PIX_W-1:0]       p_q, q_q;

  // arithmetic
  logic signed [REL_T_W-1:0] rel_t;
  logic signed [REL_V_W-1:0] rel_v, rel_v_q;
  logic [GPROD_W-1:0]     glow_prod, glow_prod_q;
  logic [GFULL_W-1:0]     glow_full;
  logic [2*REL_Q_W-1:0]   rel_full;
  logic [PIX_W-1:0]       glow_r_q, rel_r_q;
  logic                   rel_neg_q, rel_sat_q;
  logic [PIX_W-1:0]       res;

  // output register
  logic                   out_valid_q;
  logic [PIX_W-1:0]       out_pix_q;
  logic                   out_end_q;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(cfg_i.frame_width) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (int'(cfg_i.frame_height) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(cfg_i.frame_height);
    end
  end

  assign total      = CNT_W'(CNT_W'(eff_w) * CNT_W'(eff_h));
  assign lag_thr    = ({1'b0, CNT_W'(eff_w)} << 1) + (CNT_W + 1)'(2);
  assign fill       = {1'b0, acc_q} + (CNT_W + 1)'(1) - {1'b0, emit_q};
  assign pix_ok     = acc_q < total;
  assign pix_take   = cmd_i.accept && !in_mode_i && pix_ok;
  assign frame_done = ({1'b0, emit_q} + (CNT_W + 1)'(1)) >= {1'b0, total};
  assign glow       = (cfg_i.effect == EFF_GLOW);

  assign sts_o.emit_req = in_mode_i ? (emit_q < acc_q) : (pix_ok && (fill > lag_thr));
  assign sts_o.glow     = glow;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // frame counters
  always_comb begin
    acc_d      = acc_q;
    emit_d     = emit_q;
    acc_ptr_d  = acc_ptr_q;
    emit_ptr_d = emit_ptr_q;
    if (restart_i) begin
      acc_d      = '0;
      emit_d     = '0;
      acc_ptr_d  = '0;
      emit_ptr_d = '0;
    end else if (pix_take) begin
      acc_d     = acc_q + CNT_W'(1);
      acc_ptr_d = ring_inc(acc_ptr_q);
    end else if (cmd_i.wr_en) begin
      if (frame_done) begin
        acc_d      = '0;
        emit_d     = '0;
        acc_ptr_d  = '0;
        emit_ptr_d = '0;
      end else begin
        emit_d     = emit_q + CNT_W'(1);
        emit_ptr_d = ring_inc(emit_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      emit_q     <= '0;
      acc_ptr_q  <= '0;
      emit_ptr_q <= '0;
    end else begin
      acc_q      <= acc_d;
      emit_q     <= emit_d;
      acc_ptr_q  <= acc_ptr_d;
      emit_ptr_q <= emit_ptr_d;
    end
  end

  // ring memory, one write and one registered read port
  assign mem_we    = pix_take || cmd_i.wr_en;
  assign mem_waddr = cmd_i.wr_en ? emit_ptr_q : acc_ptr_q;
  assign mem_wdata = cmd_i.wr_en ? res : in_pixel_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      mem_rdata_q <= ring_mem[rd_addr];
    end
  end

  // window address walk
  assign w_off    = $signed({{(OFF_W - WID_W){1'b0}}, eff_w});
  assign addr_raw = $signed({2'b00, emit_ptr_q}) + AD_W'(off_q);
  assign pos      = $signed({2'b00, emit_q}) + POS_W'(off_q);
  assign pos_in   = (pos >= 0) && (pos[CNT_W:0] < {1'b0, acc_q});

  always_comb begin
    if (addr_raw < 0) begin
      rd_addr = RING_AW'(addr_raw + AD_W'(RING_DEPTH));
    end else if (addr_raw >= AD_W'(RING_DEPTH)) begin
      rd_addr = RING_AW'(addr_raw - AD_W'(RING_DEPTH));
    end else begin
      rd_addr = RING_AW'(addr_raw);
    end
  end

  always_comb begin
    off_d = off_q;
    col_d = col_q;
    if (cmd_i.win_init) begin
      off_d = glow ? (OFF_W'(-2) - (w_off <<< 1)) : '0;
      col_d = '0;
    end else if (cmd_i.rd_en) begin
      if (glow) begin
        if (col_q == COL_W'(GLOW_SIZE - 1)) begin
          off_d = off_q + w_off - OFF_W'(GLOW_SIZE - 1);
          col_d = '0;
        end else begin
          off_d = off_q + OFF_W'(1);
          col_d = col_q + COL_W'(1);
        end
      end else if (cfg_i.effect == EFF_HREL) begin
        off_d = OFF_W'(1);
      end else begin
        off_d = w_off + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    col_q    <= col_d;
    rd_in_q  <= pos_in;
    rd_ctr_q <= (off_q == '0);
    rd_isq_q <= !glow && (off_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  // tap accumulation
  assign rd_val = rd_in_q ? mem_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_val);
      if (rd_ctr_q) begin
        p_q <= rd_val;
      end
      if (rd_isq_q) begin
        q_q <= rd_val;
      end
    end
  end

  // first multiply stage
  assign rel_t     = $signed(REL_T_W'(RELIEF_BIAS)) - $signed({2'b00, p_q})
                     + $signed({2'b00, q_q});
  assign rel_v     = rel_t * $signed({1'b0, p_q});
  assign glow_prod = GPROD_W'(p_q) * GPROD_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      rel_v_q     <= rel_v;
      glow_prod_q <= glow_prod;
    end
  end

  // reciprocal divide stage
  assign glow_full = GFULL_W'(glow_prod_q) * GFULL_W'(GLOW_RECIP);
  assign rel_full  = (2 * REL_Q_W)'(rel_v_q[REL_Q_W-1:0]) * (2 * REL_Q_W)'(RELIEF_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_en) begin
      glow_r_q  <= glow_full[GLOW_SHIFT +: PIX_W];
      rel_r_q   <= rel_full[RELIEF_SHIFT +: PIX_W];
      rel_neg_q <= rel_v_q < 0;
      rel_sat_q <= rel_v_q >= REL_V_W'(RELIEF_SAT);
    end
  end

  always_comb begin
    case (cfg_i.effect)
      EFF_GLOW:           res = glow_r_q;
      EFF_HREL, EFF_DREL: res = rel_neg_q ? '0 : (rel_sat_q ? '1 : rel_r_q);
      default:            res = p_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wr_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      out_pix_q <= res;
      out_end_q <= frame_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pix_q;
  assign out_end_o   = out_end_q;

  a_emit_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= acc_q)
    else $error("emitted count ahead of accepted count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before beat taken");

endmodule

`default_nettype wire

// File: src/glyph_pixel_effect_filter_unit.sv
// glyph pixel effect filter top: apb config registers, sequencing fsm, ring datapath
// a beat that gives no result is only accepted; for a beat that gives a result, the
// single ring read port walks the window (25 taps glow, 2 otherwise), then flush,
// multiply, divide and write raise out valid; no new beat is taken before the write
// reset: counts cleared, config 256 x 256 glow; ring contents left as they are
`timescale 1ns / 1ps
`default_nettype none

module glyph_pixel_effect_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gpef_pkg::PADDR_W-1:0]  paddr,
  input  logic [gpef_pkg::PDATA_W-1:0]  pwdata,
  output logic [gpef_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  gpef_in_if.sink                       in_chan,
  gpef_out_if.source                    out_chan
);
  import gpef_pkg::*;

  cfg_t    cfg;
  logic    restart;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_chan.ready = in_ready;

  gpef_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  gpef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpef_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (in_chan.mode),
    .in_pixel_i  (in_chan.pixel_in),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_pixel_o (out_chan.pixel_out),
    .out_end_o   (out_chan.frame_end)
  );

endmodule

`default_nettype wire
